// ===== design/ppc_pkg.sv =====
// Shared types and constants of the pairwise proximity and CPA engine.
// No dependencies.
package ppc_pkg;

	localparam int DEF_MAX_ENTITIES = 64;
	localparam int DEF_COORD_BITS   = 24;
	localparam int DEF_TEAM_BITS    = 4;

	localparam int IDX_W      = 6;
	localparam int ENT_W      = 7;
	localparam int DIST_W     = 25;
	localparam int TIME_W     = 32;
	localparam int SQ_W       = 52;
	localparam int CMD_W      = 2;
	localparam int IN_DATA_W  = 168;
	localparam int OUT_DATA_W = 184;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int CNT_W      = 7;

	localparam int DOT_W      = 64;
	localparam int ROOT_W     = 32;
	localparam int MUL_W      = 32;
	localparam int PW         = 66;
	localparam int SQ_ACC_W   = 54;
	localparam int RESULT_LIMIT = 64;

	localparam logic [ENT_W-1:0]  NO_ENTITY = 7'd64;
	localparam logic [DIST_W-1:0] DIST_MAX  = '1;
	localparam logic [SQ_W-1:0]   SQ_MAX    = '1;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD  = 2'd0,
		CMD_SWEEP = 2'd1,
		CMD_PAIR  = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACTIVE_COUNT = 1'b0,
		REG_VEL_EPSILON  = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		DOT_DD,
		DOT_VV,
		DOT_WV
	} dot_mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_A,
		ST_LAT_A,
		ST_RD_B,
		ST_LAT_B,
		ST_DOT,
		ST_DOT_END,
		ST_SQRT,
		ST_DIV,
		ST_TIME,
		ST_CPA_MUL,
		ST_CPA_RND,
		ST_CPA_SQ,
		ST_CPA_ACC,
		ST_EMIT
	} state_t;

endpackage

// ===== design/ppc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ppc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/ppc_isqrt.sv =====
// Iterative integer square root, one result bit per cycle.
// Depends on ppc_pkg.
module ppc_isqrt
	import ppc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DOT_W-1:0]  value,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	logic             busy_q;
	logic             done_q;
	logic [DOT_W-1:0] v_q;
	logic [DOT_W-1:0] r_q;
	logic [DOT_W-1:0] bit_q;
	logic [4:0]       cnt_q;
	logic [DOT_W-1:0] rb;
	logic             take;

	always_comb begin
		rb   = r_q + bit_q;
		take = v_q >= rb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == 5'd31) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= value;
			r_q   <= '0;
			bit_q <= DOT_W'(1) << (DOT_W - 2);
			cnt_q <= '0;
		end else if (busy_q) begin
			if (take) begin
				v_q <= v_q - rb;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
			cnt_q <= cnt_q + 5'd1;
		end
	end

	assign done = done_q;
	assign root = r_q[ROOT_W-1:0];

endmodule

// ===== design/pairwise_proximity_cpa_engine.sv =====
// Pairwise proximity and closest-approach engine, top level.
// Load writes one entity slot. Each pair distance is a RAM read, 3 products on the shared
// multiplier and an iterative square root; a sweep emits one result per entity.
// A pair query skips the divide when the squared relative speed is zero or below epsilon.
// One word in flight at a time. arst_n clears control; the entity RAM is undefined until loaded.
// Depends on ppc_pkg, ppc_ram, ppc_isqrt.
module pairwise_proximity_cpa_engine
	import ppc_pkg::*;
#(
	parameter int MAX_ENTITIES = DEF_MAX_ENTITIES,
	parameter int COORD_BITS   = DEF_COORD_BITS,
	parameter int TEAM_BITS    = DEF_TEAM_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// slot_index, other_index, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, team, living
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// cmd
	input  logic [CMD_W-1:0]      s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// entity_index, nearest_enemy, nearest_distance, furthest_entity, furthest_distance,
	// pair_distance, approach_time, approach_sq_distance
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CB   = COORD_BITS;
	localparam int TB   = TEAM_BITS;
	localparam int AW   = $clog2(MAX_ENTITIES);
	localparam int EW   = 6 * CB + TB + 1;
	localparam int DW   = CB + 1;
	localparam int SW   = 2 * CB + 2;
	localparam int CW   = PW - 16;
	localparam int NLIM = (MAX_ENTITIES < RESULT_LIMIT) ? MAX_ENTITIES : RESULT_LIMIT;

	function automatic logic [CB-1:0] mag_of(input logic signed [DW-1:0] x);
		mag_of = x[DW-1] ? CB'(-x) : CB'(x);
	endfunction

	function automatic logic signed [DW-1:0] pick(input logic signed [DW-1:0] a0,
			input logic signed [DW-1:0] a1, input logic signed [DW-1:0] a2,
			input logic [1:0] k);
		case (k)
			2'd0:    pick = a0;
			2'd1:    pick = a1;
			default: pick = a2;
		endcase
	endfunction

	function automatic logic signed [DW-1:0] coord_diff(input logic [CB-1:0] a,
			input logic [CB-1:0] b);
		coord_diff = $signed({a[CB-1], a}) - $signed({b[CB-1], b});
	endfunction

	// input fields
	logic [IDX_W-1:0] in_slot;
	logic [IDX_W-1:0] in_other;
	logic [23:0]      in_px, in_py, in_pz, in_vx, in_vy, in_vz;
	logic [3:0]       in_team;
	logic             in_living;
	cmd_t             in_cmd;

	assign in_slot   = s_tdata[5:0];
	assign in_other  = s_tdata[11:6];
	assign in_px     = s_tdata[35:12];
	assign in_py     = s_tdata[59:36];
	assign in_pz     = s_tdata[83:60];
	assign in_vx     = s_tdata[107:84];
	assign in_vy     = s_tdata[131:108];
	assign in_vz     = s_tdata[155:132];
	assign in_team   = s_tdata[159:156];
	assign in_living = s_tdata[160];
	assign in_cmd    = cmd_t'(s_tuser);

	state_t state_q, next_state;

	logic [CNT_W-1:0]      active_count_q;
	logic [CFG_DATA_W-1:0] eps_q;

	logic                  sweep_q;
	logic                  pair_bad_q;
	logic [CNT_W-1:0]      n_q, i_q, j_q;
	logic [EW-1:0]         ent_a_q;
	logic signed [DW-1:0]  d_q [3];
	logic signed [DW-1:0]  dv_q [3];
	logic [TB-1:0]         team_b_q;
	logic                  living_b_q;
	dot_mode_t             mode_q;
	logic [1:0]            ax_q;
	logic [SW-1:0]         pos_acc_q, neg_acc_q;
	logic [DOT_W-1:0]      dvdv_q;
	logic                  tneg_q;
	logic [DOT_W-1:0]      rem_q;
	logic [31:0]           dsh_q;
	logic [31:0]           quo_q;
	logic [4:0]            dcnt_q;
	logic                  div_big_q;
	logic signed [TIME_W-1:0] t_q;
	logic [25:0]           c_q;
	logic                  big_q;
	logic [SQ_ACC_W-1:0]   sq_acc_q;
	logic [2*MUL_W-1:0]    prod_q;
	logic                  tsgn_q;
	logic [DIST_W-1:0]     best_near_d_q, best_far_d_q;
	logic [ENT_W-1:0]      best_near_i_q, best_far_i_q;
	logic [DIST_W-1:0]     pair_dist_q;
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  out_last_q;

	// combinational helpers
	logic                  accept;
	logic                  out_free;
	logic [CNT_W-1:0]      n_in;
	logic                  in_bad;
	logic                  mem_we;
	logic [AW-1:0]         mem_raddr;
	logic [EW-1:0]         wr_word;
	logic [EW-1:0]         mem_rdata;
	logic [MUL_W-1:0]      mul_a, mul_b;
	logic                  mul_sgn;
	logic                  sqrt_start;
	logic                  sqrt_done;
	logic [ROOT_W-1:0]     sqrt_root;
	logic [DIST_W-1:0]     root_sat;
	logic [DOT_W-1:0]      pos_sat, neg_sat, dot_res;
	logic                  dot_neg;
	logic                  vv_ok;
	logic signed [DW-1:0]  d_ax, dv_ax;
	logic [MUL_W-1:0]      t_mag;
	logic [DOT_W:0]        div_r2, div_diff;
	logic                  div_ge;
	logic [32:0]           m_val, m_neg_cap;
	logic signed [TIME_W-1:0] t_new;
	logic [62:0]           pm;
	logic signed [PW-1:0]  w0s, p_val;
	logic [PW-1:0]         p_abs;
	logic [CW-1:0]         c_val;
	logic [SQ_W:0]         sq_term;
	logic [SQ_W-1:0]       sq_out;
	logic                  last_result;
	logic [TB-1:0]         team_a;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign team_a   = ent_a_q[6*CB +: TB];

	always_comb begin
		n_in = (active_count_q > CNT_W'(NLIM)) ? CNT_W'(NLIM) : active_count_q;
		in_bad = (32'(in_slot) >= 32'(MAX_ENTITIES)) || (32'(in_other) >= 32'(MAX_ENTITIES));
		wr_word = {in_living, TB'(in_team),
			CB'(signed'(in_vz)), CB'(signed'(in_vy)), CB'(signed'(in_vx)),
			CB'(signed'(in_pz)), CB'(signed'(in_py)), CB'(signed'(in_px))};
		d_ax  = pick(d_q[0], d_q[1], d_q[2], ax_q);
		dv_ax = pick(dv_q[0], dv_q[1], dv_q[2], ax_q);
		t_mag = t_q[TIME_W-1] ? MUL_W'(-t_q) : MUL_W'(t_q);
		root_sat = (sqrt_root > ROOT_W'(DIST_MAX)) ? DIST_MAX : sqrt_root[DIST_W-1:0];
		last_result = (i_q + CNT_W'(1)) == n_q;
	end

	// signed dot product result from the two magnitude accumulators
	always_comb begin
		pos_sat = (SW > DOT_W && (pos_acc_q >> DOT_W) != '0) ? '1 : DOT_W'(pos_acc_q);
		neg_sat = (SW > DOT_W && (neg_acc_q >> DOT_W) != '0) ? '1 : DOT_W'(neg_acc_q);
		if (pos_sat >= neg_sat) begin
			dot_res = pos_sat - neg_sat;
			dot_neg = 1'b0;
		end else begin
			dot_res = neg_sat - pos_sat;
			dot_neg = 1'b1;
		end
		vv_ok = (dot_res != '0) && (dot_res >= DOT_W'(eps_q));
	end

	// restoring divide step and approach time
	always_comb begin
		div_r2   = {rem_q, dsh_q[31]};
		div_diff = div_r2 - {1'b0, dvdv_q};
		div_ge   = div_r2 >= {1'b0, dvdv_q};
		m_val    = div_big_q ? 33'h1_0000_0000 : {1'b0, quo_q};
		m_neg_cap = (m_val > 33'h0_8000_0000) ? 33'h0_8000_0000 : m_val;
		if (tneg_q) begin
			t_new = (m_val > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(m_val[31:0]);
		end else begin
			t_new = signed'(m_neg_cap[31:0]);
			t_new = -t_new;
		end
	end

	// CPA axis position rounding and term
	always_comb begin
		pm    = (prod_q > 64'h4000_0000_0000_0000) ? 63'h4000_0000_0000_0000 : prod_q[62:0];
		w0s   = PW'(d_ax) <<< 16;
		p_val = (dv_ax[DW-1] ^ t_q[TIME_W-1]) ? w0s - signed'(PW'(pm)) : w0s + signed'(PW'(pm));
		p_abs = p_val[PW-1] ? PW'(-p_val) : PW'(p_val);
		c_val = CW'((p_abs + PW'(32768)) >> 16);
		sq_term = big_q ? ((SQ_W+1)'(1) << SQ_W) : (SQ_W+1)'(prod_q[SQ_W-1:0]);
		sq_out  = (sq_acc_q > SQ_ACC_W'(SQ_MAX)) ? SQ_MAX : sq_acc_q[SQ_W-1:0];
	end

	// control outputs
	always_comb begin
		s_tready   = state_q == ST_IDLE;
		mem_we     = 1'b0;
		mem_raddr  = (state_q == ST_RD_B) ? AW'(j_q) : AW'(i_q);
		mul_a      = '0;
		mul_b      = '0;
		mul_sgn    = 1'b0;
		sqrt_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				mem_we = accept && in_cmd == CMD_LOAD && 32'(in_slot) < 32'(MAX_ENTITIES);
			end
			ST_DOT: begin
				case (mode_q)
					DOT_DD: begin
						mul_a = MUL_W'(mag_of(d_ax));
						mul_b = MUL_W'(mag_of(d_ax));
					end
					DOT_VV: begin
						mul_a = MUL_W'(mag_of(dv_ax));
						mul_b = MUL_W'(mag_of(dv_ax));
					end
					default: begin
						mul_a   = MUL_W'(mag_of(d_ax));
						mul_b   = MUL_W'(mag_of(dv_ax));
						mul_sgn = d_ax[DW-1] ^ dv_ax[DW-1];
					end
				endcase
			end
			ST_DOT_END: begin
				sqrt_start = mode_q == DOT_DD;
			end
			ST_CPA_MUL: begin
				mul_a = MUL_W'(mag_of(dv_ax));
				mul_b = t_mag;
			end
			ST_CPA_SQ: begin
				mul_a = MUL_W'(c_q);
				mul_b = MUL_W'(c_q);
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		next_state = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_cmd)
						CMD_SWEEP: next_state = (n_in != '0) ? ST_RD_A : ST_IDLE;
						CMD_PAIR:  next_state = in_bad ? ST_EMIT : ST_RD_A;
						default:   next_state = ST_IDLE;
					endcase
				end
			end
			ST_RD_A:  next_state = ST_LAT_A;
			ST_LAT_A: next_state = ST_RD_B;
			ST_RD_B: begin
				if (!sweep_q) begin
					next_state = ST_LAT_B;
				end else if (j_q == n_q) begin
					next_state = ST_EMIT;
				end else if (j_q == i_q) begin
					next_state = ST_RD_B;
				end else begin
					next_state = ST_LAT_B;
				end
			end
			ST_LAT_B: next_state = ST_DOT;
			ST_DOT:   next_state = (ax_q == 2'd3) ? ST_DOT_END : ST_DOT;
			ST_DOT_END: begin
				case (mode_q)
					DOT_DD:  next_state = ST_SQRT;
					DOT_VV:  next_state = vv_ok ? ST_DOT : ST_CPA_MUL;
					default: next_state = ST_DIV;
				endcase
			end
			ST_SQRT: begin
				if (sqrt_done) begin
					next_state = sweep_q ? ST_RD_B : ST_DOT;
				end
			end
			ST_DIV: begin
				if (div_big_q || dcnt_q == 5'd31) begin
					next_state = ST_TIME;
				end
			end
			ST_TIME:    next_state = ST_CPA_MUL;
			ST_CPA_MUL: next_state = ST_CPA_RND;
			ST_CPA_RND: next_state = ST_CPA_SQ;
			ST_CPA_SQ:  next_state = ST_CPA_ACC;
			ST_CPA_ACC: next_state = (ax_q == 2'd2) ? ST_EMIT : ST_CPA_MUL;
			ST_EMIT: begin
				if (out_free) begin
					next_state = (!sweep_q || last_result) ? ST_IDLE : ST_RD_A;
				end
			end
			default: next_state = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			m_tvalid_q     <= 1'b0;
			active_count_q <= '0;
			eps_q          <= CFG_DATA_W'(1);
		end else begin
			state_q <= next_state;
			if (state_q == ST_EMIT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_ACTIVE_COUNT: active_count_q <= cfg_data[CNT_W-1:0];
					REG_VEL_EPSILON:  eps_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		tsgn_q <= mul_sgn;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					sweep_q    <= in_cmd == CMD_SWEEP;
					n_q        <= n_in;
					pair_bad_q <= in_bad;
					i_q        <= (in_cmd == CMD_SWEEP) ? '0 : CNT_W'(in_slot);
					j_q        <= CNT_W'(in_other);
				end
			end
			ST_LAT_A: begin
				ent_a_q <= mem_rdata;
				if (sweep_q) begin
					j_q <= '0;
				end
				best_near_d_q <= DIST_MAX;
				best_near_i_q <= NO_ENTITY;
				best_far_d_q  <= '0;
				best_far_i_q  <= NO_ENTITY;
			end
			ST_RD_B: begin
				if (sweep_q && j_q != n_q && j_q == i_q) begin
					j_q <= j_q + CNT_W'(1);
				end
			end
			ST_LAT_B: begin
				for (int k = 0; k < 3; k++) begin
					d_q[k]  <= coord_diff(ent_a_q[k*CB +: CB], mem_rdata[k*CB +: CB]);
					dv_q[k] <= coord_diff(ent_a_q[(k+3)*CB +: CB], mem_rdata[(k+3)*CB +: CB]);
				end
				team_b_q   <= mem_rdata[6*CB +: TB];
				living_b_q <= mem_rdata[6*CB+TB];
				mode_q     <= DOT_DD;
				ax_q       <= '0;
				pos_acc_q  <= '0;
				neg_acc_q  <= '0;
			end
			ST_DOT: begin
				ax_q <= ax_q + 2'd1;
				if (ax_q != 2'd0) begin
					if (tsgn_q) begin
						neg_acc_q <= neg_acc_q + SW'(prod_q);
					end else begin
						pos_acc_q <= pos_acc_q + SW'(prod_q);
					end
				end
			end
			ST_DOT_END: begin
				ax_q      <= '0;
				pos_acc_q <= '0;
				neg_acc_q <= '0;
				case (mode_q)
					DOT_VV: begin
						dvdv_q   <= dot_res;
						mode_q   <= DOT_WV;
						t_q      <= '0;
						sq_acc_q <= '0;
					end
					DOT_WV: begin
						tneg_q    <= dot_neg;
						rem_q     <= dot_res >> 16;
						dsh_q     <= {dot_res[15:0], 16'h0};
						quo_q     <= '0;
						dcnt_q    <= '0;
						div_big_q <= (dot_res >> 16) >= dvdv_q;
					end
					default: begin
					end
				endcase
			end
			ST_SQRT: begin
				if (sqrt_done) begin
					if (sweep_q) begin
						if (root_sat < best_near_d_q && living_b_q && team_b_q != team_a) begin
							best_near_d_q <= root_sat;
							best_near_i_q <= j_q;
						end
						if (root_sat > best_far_d_q) begin
							best_far_d_q <= root_sat;
							best_far_i_q <= j_q;
						end
						j_q <= j_q + CNT_W'(1);
					end else begin
						pair_dist_q <= root_sat;
						mode_q      <= DOT_VV;
						ax_q        <= '0;
						pos_acc_q   <= '0;
						neg_acc_q   <= '0;
					end
				end
			end
			ST_DIV: begin
				rem_q  <= div_ge ? div_diff[DOT_W-1:0] : div_r2[DOT_W-1:0];
				quo_q  <= {quo_q[30:0], div_ge};
				dsh_q  <= dsh_q << 1;
				dcnt_q <= dcnt_q + 5'd1;
			end
			ST_TIME: begin
				t_q      <= t_new;
				ax_q     <= '0;
				sq_acc_q <= '0;
			end
			ST_CPA_RND: begin
				c_q   <= c_val[25:0];
				big_q <= c_val[CW-1:26] != '0;
			end
			ST_CPA_ACC: begin
				sq_acc_q <= sq_acc_q + SQ_ACC_W'(sq_term);
				ax_q     <= ax_q + 2'd1;
			end
			ST_EMIT: begin
				if (out_free) begin
					if (sweep_q) begin
						out_data_q <= {5'd0, SQ_W'(0), TIME_W'(0), DIST_W'(0),
							best_far_d_q, best_far_i_q, best_near_d_q, best_near_i_q,
							i_q[IDX_W-1:0]};
						out_last_q <= last_result;
						i_q        <= i_q + CNT_W'(1);
					end else if (pair_bad_q) begin
						out_data_q <= {5'd0, SQ_W'(0), TIME_W'(0), DIST_W'(0),
							DIST_W'(0), NO_ENTITY, DIST_W'(0), NO_ENTITY, i_q[IDX_W-1:0]};
						out_last_q <= 1'b1;
					end else begin
						out_data_q <= {5'd0, sq_out, t_q, pair_dist_q,
							DIST_W'(0), NO_ENTITY, DIST_W'(0), NO_ENTITY, i_q[IDX_W-1:0]};
						out_last_q <= 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		if (state_q == ST_DOT_END && mode_q == DOT_VV && !vv_ok) begin
			mode_q <= DOT_DD;
		end
	end

	ppc_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_ENTITIES)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (AW'(in_slot)),
		.wdata (wr_word),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	ppc_isqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.value  (dot_res),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule
